FILE: rtl/core/kbt_pkg.sv
`default_nettype none
package kbt_pkg;

	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 32;
	localparam int SW         = COORD_BITS + FRAC_BITS;
	localparam int CW         = 64;
	localparam int NOISE_BITS = 32;
	localparam int AXES       = 4;
	localparam int RESCALE_SH = (FRAC_BITS >= NOISE_BITS) ? FRAC_BITS - NOISE_BITS
	                                                      : NOISE_BITS - FRAC_BITS;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [SW-1:0]         fix_t;
	typedef logic [CW-1:0]                cov_t;
	typedef logic [NOISE_BITS-1:0]        noise_t;
	typedef logic [1:0]                   op_t;
	typedef logic [1:0]                   reg_idx_t;

	localparam op_t OP_INIT     = 2'd0;
	localparam op_t OP_UPDATE   = 2'd1;
	localparam op_t OP_REUSE    = 2'd2;
	localparam op_t OP_RESERVED = 2'd3;

	localparam reg_idx_t REG_PROCESS_NOISE     = 2'd0;
	localparam reg_idx_t REG_MEASUREMENT_NOISE = 2'd1;

	localparam noise_t PROCESS_NOISE_RST     = 32'd42950;
	localparam noise_t MEASUREMENT_NOISE_RST = 32'd429496730;

	localparam cov_t ONE_F   = cov_t'(1) << FRAC_BITS;
	localparam cov_t COV_MAX = '1;
	localparam fix_t SMAX    = {1'b0, {(SW-1){1'b1}}};
	localparam fix_t SMIN    = {1'b1, {(SW-1){1'b0}}};
	localparam coord_t CMAX  = {1'b0, {(COORD_BITS-1){1'b1}}};

	function automatic cov_t rescale(input noise_t v);
		cov_t w;
		w = cov_t'(v);
		if (FRAC_BITS >= NOISE_BITS)
			return w << RESCALE_SH;
		else
			return w >> RESCALE_SH;
	endfunction

	function automatic cov_t usat_add(input cov_t a, input cov_t b);
		logic [CW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CW] ? COV_MAX : s[CW-1:0];
	endfunction

	// a +/- m, saturated to the estimate range
	function automatic fix_t add_mag(input fix_t a, input cov_t m, input logic neg);
		logic signed [CW+1:0] s;
		if (neg)
			s = (CW+2)'(a) - $signed({2'b00, m});
		else
			s = (CW+2)'(a) + $signed({2'b00, m});
		if (s > (CW+2)'(SMAX))
			return SMAX;
		else if (s < (CW+2)'(SMIN))
			return SMIN;
		else
			return s[SW-1:0];
	endfunction

	// truncate toward zero, saturate to the coordinate range
	function automatic coord_t to_coord(input fix_t v);
		logic [SW:0]         mag;
		logic [COORD_BITS:0] t;
		mag = v[SW-1] ? ((SW+1)'(0) - (SW+1)'(v)) : (SW+1)'(v);
		t   = mag[SW:FRAC_BITS];
		if (v[SW-1])
			return coord_t'((COORD_BITS+1)'(0) - t);
		else if (t > (COORD_BITS+1)'(CMAX))
			return CMAX;
		else
			return t[COORD_BITS-1:0];
	endfunction

	function automatic fix_t to_fixed(input coord_t z);
		return $signed({z, {FRAC_BITS{1'b0}}});
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/kbt_if.sv
`default_nettype none
interface kbt_in_if;
	import kbt_pkg::*;
	logic   valid;
	logic   ready;
	op_t    op;
	coord_t meas_x;
	coord_t meas_y;
	coord_t meas_w;
	coord_t meas_h;
	modport source (output valid, op, meas_x, meas_y, meas_w, meas_h, input ready);
	modport sink   (input valid, op, meas_x, meas_y, meas_w, meas_h, output ready);
endinterface

interface kbt_out_if;
	import kbt_pkg::*;
	logic   valid;
	logic   ready;
	logic   tracking_on;
	coord_t pred_x;
	coord_t pred_y;
	coord_t pred_w;
	coord_t pred_h;
	coord_t est_x;
	coord_t est_y;
	coord_t est_w;
	coord_t est_h;
	modport source (output valid, tracking_on, pred_x, pred_y, pred_w, pred_h,
		est_x, est_y, est_w, est_h, input ready);
	modport sink   (input valid, tracking_on, pred_x, pred_y, pred_w, pred_h,
		est_x, est_y, est_w, est_h, output ready);
endinterface

interface kbt_cfg_if;
	import kbt_pkg::*;
	logic     valid;
	logic     ready;
	reg_idx_t index;
	noise_t   data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/kbt_muldiv.sv
`default_nettype none
// floor(a*b/c), saturated to all ones; shift-add multiply then restoring divide.
// With pow2 set, c is taken as 2^FRAC_BITS and the divide is a plain shift.
module kbt_muldiv (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic         pow2,
	input  wire kbt_pkg::cov_t a,
	input  wire kbt_pkg::cov_t b,
	input  wire kbt_pkg::cov_t c,
	output logic              done,
	output kbt_pkg::cov_t     q
);
	import kbt_pkg::*;

	typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_CHK, MD_DIV} md_state_t;

	md_state_t         state_q;
	logic [5:0]        cnt_q;
	cov_t              a_q, b_q, c_q, rem_q, quo_q;
	logic [2*CW-1:0]   prod_q;
	logic              done_q;
	logic              pow2_q;
	cov_t              q_q;

	logic [CW:0]       trial;
	cov_t              r2;

	always_comb begin
		r2    = {rem_q[CW-2:0], prod_q[CW-1]};
		trial = {rem_q[CW-1], r2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				MD_IDLE: begin
					if (start) begin
						a_q     <= a;
						b_q     <= b;
						c_q     <= c;
						pow2_q  <= pow2;
						prod_q  <= '0;
						cnt_q   <= '0;
						state_q <= MD_MUL;
					end
				end
				MD_MUL: begin
					prod_q <= (prod_q << 1) + (b_q[CW-1] ? (2*CW)'(a_q) : '0);
					b_q    <= b_q << 1;
					cnt_q  <= cnt_q + 6'd1;
					if (&cnt_q)
						state_q <= MD_CHK;
				end
				MD_CHK: begin
					if (pow2_q) begin
						q_q     <= (|prod_q[2*CW-1:CW+FRAC_BITS]) ? COV_MAX
						                                          : prod_q[CW+FRAC_BITS-1:FRAC_BITS];
						done_q  <= 1'b1;
						state_q <= MD_IDLE;
					end else if (prod_q[2*CW-1:CW] >= c_q) begin
						q_q     <= COV_MAX;
						done_q  <= 1'b1;
						state_q <= MD_IDLE;
					end else begin
						rem_q   <= prod_q[2*CW-1:CW];
						quo_q   <= '0;
						cnt_q   <= '0;
						state_q <= MD_DIV;
					end
				end
				MD_DIV: begin
					if (trial >= {1'b0, c_q}) begin
						rem_q <= r2 - c_q;
						quo_q <= {quo_q[CW-2:0], 1'b1};
					end else begin
						rem_q <= r2;
						quo_q <= {quo_q[CW-2:0], 1'b0};
					end
					prod_q[CW-1:0] <= prod_q[CW-1:0] << 1;
					cnt_q <= cnt_q + 6'd1;
					if (&cnt_q) begin
						q_q     <= (trial >= {1'b0, c_q}) ? {quo_q[CW-2:0], 1'b1}
						                                 : {quo_q[CW-2:0], 1'b0};
						done_q  <= 1'b1;
						state_q <= MD_IDLE;
					end
				end
				default: state_q <= MD_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign q    = q_q;
endmodule
`default_nettype wire

FILE: rtl/core/box_kalman_tracker_top.sv
`default_nettype none
// Bounding-box tracker: constant-velocity Kalman filter on x, y, w, h with one
// shared covariance. One transaction in gives one transaction out holding the
// predicted and the corrected box. Init and the no-op cases go straight from
// the idle state to the output state. Most of an update is spent in the single
// shared multiply/divide unit: the two gains are true divides (64 shift-add
// steps, a range check, 64 divide steps), and the eight corrections and three
// covariance terms are products scaled by 2^FRAC_BITS, where that divide is a
// shift. Prep, per-axis and output states come between them. The input is not
// ready while an update runs; a finished result waits in the output register
// without blocking the next input transaction, and the next result waits in the
// sequencer until that register drains. Noise registers take writes at any time
// (cfg.ready is always high) but should only change while the block is idle.
module box_kalman_tracker_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	kbt_in_if.sink     item_in,
	kbt_out_if.source  item_out,
	kbt_cfg_if.sink    cfg
);
	import kbt_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_PREP1, S_PREP2, S_PREP3, S_PREP4, S_K0, S_K1,
		S_AXP, S_AXE, S_M0, S_M1, S_C0, S_C1, S_C2, S_OUT
	} state_t;

	state_t   state_q;
	logic     valid_q;
	noise_t   qn_q, rn_q;
	coord_t   last_q [AXES];
	fix_t     pos_q  [AXES];
	fix_t     vel_q  [AXES];
	cov_t     p0_q, p1_q, p2_q;
	cov_t     p00_q, p01_q, p11_q, s_q, k0_q, k1_q, tmp_q;
	fix_t     pp_q;
	cov_t     e_q;
	logic     neg_q;
	logic [1:0] ax_q;
	logic     md_busy_q;
	coord_t   rpred_q [AXES];
	coord_t   rest_q  [AXES];
	logic     rtrk_q;

	logic     out_valid_q;
	logic     out_trk_q;
	coord_t   out_pred_q [AXES];
	coord_t   out_est_q  [AXES];

	cov_t     qf, rf;
	cov_t     md_a, md_b, md_c, md_q;
	logic     md_start, md_done, md_phase, md_pow2;
	logic     in_acc;
	coord_t   meas [AXES];
	fix_t     zf;
	logic signed [SW:0] diff;

	assign item_in.ready = (state_q == S_IDLE);
	assign in_acc        = item_in.valid && item_in.ready;
	assign cfg.ready     = 1'b1;
	assign meas[0] = item_in.meas_x;
	assign meas[1] = item_in.meas_y;
	assign meas[2] = item_in.meas_w;
	assign meas[3] = item_in.meas_h;

	always_comb begin
		qf = rescale(qn_q);
		rf = rescale(rn_q);
		if (rf == '0)
			rf = cov_t'(1);
		zf   = to_fixed(last_q[ax_q]);
		diff = (SW+1)'(zf) - (SW+1)'(pp_q);
	end

	// operand select for the shared multiply/divide; products scaled by 2^F
	// take the shift path
	always_comb begin
		md_phase = 1'b1;
		md_pow2  = 1'b1;
		md_a     = '0;
		md_b     = '0;
		md_c     = ONE_F;
		case (state_q)
			S_K0: begin md_a = p00_q; md_b = ONE_F; md_c = s_q; md_pow2 = 1'b0; end
			S_K1: begin md_a = p01_q; md_b = ONE_F; md_c = s_q; md_pow2 = 1'b0; end
			S_M0: begin md_a = e_q;   md_b = k0_q; end
			S_M1: begin md_a = e_q;   md_b = k1_q; end
			S_C0: begin md_a = k0_q;  md_b = p00_q; end
			S_C1: begin md_a = k0_q;  md_b = p01_q; end
			S_C2: begin md_a = k1_q;  md_b = p01_q; end
			default: md_phase = 1'b0;
		endcase
		md_start = md_phase && !md_busy_q;
	end

	kbt_muldiv u_md (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (md_start),
		.pow2   (md_pow2),
		.a      (md_a),
		.b      (md_b),
		.c      (md_c),
		.done   (md_done),
		.q      (md_q)
	);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qn_q <= PROCESS_NOISE_RST;
			rn_q <= MEASUREMENT_NOISE_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_PROCESS_NOISE:     qn_q <= cfg.data;
				REG_MEASUREMENT_NOISE: rn_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// sequencer and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			valid_q   <= 1'b0;
			md_busy_q <= 1'b0;
			ax_q      <= '0;
			p0_q      <= '0;
			p1_q      <= '0;
			p2_q      <= '0;
			for (int i = 0; i < AXES; i++) begin
				last_q[i] <= '0;
				pos_q[i]  <= '0;
				vel_q[i]  <= '0;
			end
		end else begin
			if (md_start)
				md_busy_q <= 1'b1;
			else if (md_done)
				md_busy_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						for (int i = 0; i < AXES; i++) begin
							rpred_q[i] <= '0;
							rest_q[i]  <= '0;
						end
						rtrk_q <= valid_q;
						case (item_in.op)
							OP_INIT: begin
								for (int i = 0; i < AXES; i++) begin
									pos_q[i]   <= to_fixed(meas[i]);
									vel_q[i]   <= '0;
									rpred_q[i] <= meas[i];
									rest_q[i]  <= meas[i];
								end
								p0_q    <= ONE_F;
								p1_q    <= '0;
								p2_q    <= ONE_F;
								valid_q <= 1'b1;
								rtrk_q  <= 1'b1;
								state_q <= S_OUT;
							end
							OP_UPDATE: begin
								if (!valid_q) begin
									for (int i = 0; i < AXES; i++) begin
										pos_q[i] <= to_fixed(meas[i]);
										vel_q[i] <= '0;
									end
									p0_q    <= ONE_F;
									p1_q    <= '0;
									p2_q    <= ONE_F;
									valid_q <= 1'b1;
								end
								for (int i = 0; i < AXES; i++)
									last_q[i] <= meas[i];
								state_q <= S_PREP1;
							end
							OP_REUSE: state_q <= valid_q ? S_PREP1 : S_OUT;
							default:  state_q <= S_OUT;
						endcase
					end
				end
				S_PREP1: begin
					tmp_q   <= usat_add(p0_q, p1_q);
					p01_q   <= usat_add(p1_q, p2_q);
					p11_q   <= usat_add(p2_q, qf);
					state_q <= S_PREP2;
				end
				S_PREP2: begin
					tmp_q   <= usat_add(tmp_q, p01_q);
					state_q <= S_PREP3;
				end
				S_PREP3: begin
					p00_q   <= usat_add(tmp_q, qf);
					state_q <= S_PREP4;
				end
				S_PREP4: begin
					s_q     <= usat_add(p00_q, rf);
					state_q <= S_K0;
				end
				S_K0: if (md_done) begin k0_q <= md_q; state_q <= S_K1; end
				S_K1: if (md_done) begin
					k1_q    <= md_q;
					ax_q    <= '0;
					state_q <= S_AXP;
				end
				S_AXP: begin
					pp_q    <= add_mag(pos_q[ax_q], cov_t'(vel_q[ax_q][SW-1]
						? (SW+1)'(0) - (SW+1)'(vel_q[ax_q]) : (SW+1)'(vel_q[ax_q])),
						vel_q[ax_q][SW-1]);
					state_q <= S_AXE;
				end
				S_AXE: begin
					neg_q   <= diff[SW];
					e_q     <= cov_t'(diff[SW] ? (SW+1)'(0) - diff : diff);
					rpred_q[ax_q] <= to_coord(pp_q);
					state_q <= S_M0;
				end
				S_M0: if (md_done) begin
					pos_q[ax_q] <= add_mag(pp_q, md_q, neg_q);
					state_q     <= S_M1;
				end
				S_M1: if (md_done) begin
					vel_q[ax_q]  <= add_mag(vel_q[ax_q], md_q, neg_q);
					rest_q[ax_q] <= to_coord(pos_q[ax_q]);
					ax_q         <= ax_q + 2'd1;
					state_q      <= (ax_q == 2'(AXES-1)) ? S_C0 : S_AXP;
				end
				S_C0: if (md_done) begin p0_q <= p00_q - md_q; state_q <= S_C1; end
				S_C1: if (md_done) begin p1_q <= p01_q - md_q; state_q <= S_C2; end
				S_C2: if (md_done) begin
					p2_q    <= (md_q > p11_q) ? '0 : p11_q - md_q;
					rtrk_q  <= 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: if (!out_valid_q || item_out.ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && (!out_valid_q || item_out.ready)) begin
			out_valid_q <= 1'b1;
		end else if (item_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!out_valid_q || item_out.ready)) begin
			out_trk_q <= rtrk_q;
			for (int i = 0; i < AXES; i++) begin
				out_pred_q[i] <= rpred_q[i];
				out_est_q[i]  <= rest_q[i];
			end
		end
	end

	assign item_out.valid       = out_valid_q;
	assign item_out.tracking_on = out_trk_q;
	assign item_out.pred_x      = out_pred_q[0];
	assign item_out.pred_y      = out_pred_q[1];
	assign item_out.pred_w      = out_pred_q[2];
	assign item_out.pred_h      = out_pred_q[3];
	assign item_out.est_x       = out_est_q[0];
	assign item_out.est_y       = out_est_q[1];
	assign item_out.est_w       = out_est_q[2];
	assign item_out.est_h       = out_est_q[3];
endmodule
`default_nettype wire

FILE: rtl/core/kbt_checker.sv
`default_nettype none
module kbt_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           in_valid,
	input wire logic           in_ready,
	input wire logic           out_valid,
	input wire logic           out_ready,
	input wire logic           tracking_on,
	input wire kbt_pkg::coord_t pred_x,
	input wire kbt_pkg::coord_t est_x,
	input wire kbt_pkg::coord_t est_h
);
	import kbt_pkg::*;

	// one transaction at a time: busy right after accepting
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after accept");

	// no tracking means an all-zero box
	a_untracked_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !tracking_on |-> pred_x == '0 && est_x == '0 && est_h == '0)
		else $error("nonzero box while not tracking");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(est_x) && $stable(tracking_on))
		else $error("stalled result changed");
endmodule

bind box_kalman_tracker_top kbt_checker u_kbt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (item_in.valid),
	.in_ready    (item_in.ready),
	.out_valid   (item_out.valid),
	.out_ready   (item_out.ready),
	.tracking_on (item_out.tracking_on),
	.pred_x      (item_out.pred_x),
	.est_x       (item_out.est_x),
	.est_h       (item_out.est_h)
);
`default_nettype wire

FILE: sim/tb_box_kalman_tracker_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_box_kalman_tracker_top;
	import kbt_pkg::*;

	localparam int PHASE_ITEMS = 160;
	localparam int HOLD_CYCLES = 6000;   // long enough to back up the input behind a held result
	localparam int STALL_LIMIT = 40000;  // idle cycles before the watchdog fires

	// one box: predicted and corrected, as the block reports it
	typedef struct {
		logic   on;
		coord_t pred [AXES];
		coord_t est  [AXES];
	} box_result_t;

	typedef struct {
		op_t    op;
		coord_t z [AXES];
	} meas_item_t;

	logic clk;
	logic arst_n;

	kbt_in_if  item_in ();
	kbt_out_if item_out ();
	kbt_cfg_if cfg ();

	box_kalman_tracker_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_in  (item_in.sink),
		.item_out (item_out.source),
		.cfg      (cfg.sink)
	);

	// tracker state mirrored by the predictor
	noise_t q_noise;
	noise_t r_noise;
	logic   trk_on;
	coord_t last_meas [AXES];
	fix_t   pos [AXES];
	fix_t   vel [AXES];
	cov_t   p00, p01, p11;

	meas_item_t  pending_meas [$];
	box_result_t expected_boxes [$];

	int  errors;
	int  n_in, n_out, n_cfg, n_updates;
	bit  quiet;       // no idling on either side
	bit  hold_req;
	int  idle_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Fixed-point helpers for the predictor
	// ---------------------------------------------------------------
	function automatic cov_t sat_sum(cov_t a, cov_t b);
		logic [CW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CW] ? '1 : s[CW-1:0];
	endfunction

	// a moved by m in the given direction, clipped to the estimate width
	function automatic fix_t nudge(fix_t a, cov_t m, logic down);
		logic signed [CW+1:0] s, hi, lo;
		hi = {{(CW+2-SW){1'b0}}, 1'b0, {(SW-1){1'b1}}};
		lo = -hi - 1;
		s  = a;
		s  = down ? s - $signed({2'b00, m}) : s + $signed({2'b00, m});
		if (s > hi)
			return {1'b0, {(SW-1){1'b1}}};
		if (s < lo)
			return {1'b1, {(SW-1){1'b0}}};
		return s[SW-1:0];
	endfunction

	// floor(a*b/c), clipped to 64 bits
	function automatic cov_t scaled_ratio(cov_t a, cov_t b, cov_t c);
		logic [2*CW-1:0] prod, quo;
		prod = {{CW{1'b0}}, a} * {{CW{1'b0}}, b};
		quo  = prod / {{CW{1'b0}}, c};
		return (quo[2*CW-1:CW] != 0) ? '1 : quo[CW-1:0];
	endfunction

	function automatic cov_t noise_scale(noise_t v);
		cov_t w;
		w = v;
		return (FRAC_BITS >= NOISE_BITS) ? w << (FRAC_BITS - NOISE_BITS)
		                                 : w >> (NOISE_BITS - FRAC_BITS);
	endfunction

	function automatic fix_t pix_to_fix(coord_t z);
		fix_t f;
		f = z;
		return f <<< FRAC_BITS;
	endfunction

	// truncate toward zero, then clip to the pixel range
	function automatic coord_t fix_to_pix(fix_t v);
		logic [SW:0]  mag;
		longint       t;
		mag = v[SW-1] ? -{v[SW-1], v} : {1'b0, v};
		t   = longint'(mag >> FRAC_BITS);
		if (v[SW-1])
			t = -t;
		if (t > (longint'(1) << (COORD_BITS-1)) - 1)
			t = (longint'(1) << (COORD_BITS-1)) - 1;
		if (t < -(longint'(1) << (COORD_BITS-1)))
			t = -(longint'(1) << (COORD_BITS-1));
		return coord_t'(t);
	endfunction

	function automatic void start_track(coord_t z [AXES]);
		for (int i = 0; i < AXES; i++) begin
			pos[i] = pix_to_fix(z[i]);
			vel[i] = '0;
		end
		p00 = cov_t'(1) << FRAC_BITS;
		p01 = '0;
		p11 = cov_t'(1) << FRAC_BITS;
		trk_on = 1'b1;
	endfunction

	function automatic void track_step(inout box_result_t res);
		cov_t q, r, pp00, pp01, pp11, s, k0, k1, t, one, e;
		fix_t pp, zf;
		logic down;
		one  = cov_t'(1) << FRAC_BITS;
		q    = noise_scale(q_noise);
		r    = noise_scale(r_noise);
		if (r == 0)
			r = 1;
		pp00 = sat_sum(sat_sum(sat_sum(p00, p01), sat_sum(p01, p11)), q);
		pp01 = sat_sum(p01, p11);
		pp11 = sat_sum(p11, q);
		s    = sat_sum(pp00, r);
		k0   = scaled_ratio(pp00, one, s);
		k1   = scaled_ratio(pp01, one, s);
		for (int i = 0; i < AXES; i++) begin
			pp   = nudge(pos[i], vel[i][SW-1] ? cov_t'(-{{(CW-SW){vel[i][SW-1]}}, vel[i]})
			                                   : cov_t'(vel[i]), vel[i][SW-1]);
			zf   = pix_to_fix(last_meas[i]);
			down = zf < pp;
			e    = down ? cov_t'({{(CW-SW){pp[SW-1]}}, pp} - {{(CW-SW){zf[SW-1]}}, zf})
			            : cov_t'({{(CW-SW){zf[SW-1]}}, zf} - {{(CW-SW){pp[SW-1]}}, pp});
			res.pred[i] = fix_to_pix(pp);
			pos[i]      = nudge(pp, scaled_ratio(e, k0, one), down);
			vel[i]      = nudge(vel[i], scaled_ratio(e, k1, one), down);
			res.est[i]  = fix_to_pix(pos[i]);
		end
		p00 = pp00 - scaled_ratio(k0, pp00, one);
		p01 = pp01 - scaled_ratio(k0, pp01, one);
		t   = scaled_ratio(k1, pp01, one);
		p11 = (t > pp11) ? '0 : pp11 - t;
		n_updates++;
	endfunction

	// expected result for one accepted measurement
	function automatic box_result_t predict_box(meas_item_t m);
		box_result_t res;
		for (int i = 0; i < AXES; i++) begin
			res.pred[i] = '0;
			res.est[i]  = '0;
		end
		case (m.op)
			OP_INIT: begin
				start_track(m.z);
				for (int i = 0; i < AXES; i++) begin
					res.pred[i] = fix_to_pix(pos[i]);
					res.est[i]  = res.pred[i];
				end
			end
			OP_UPDATE: begin
				if (!trk_on)
					start_track(m.z);
				for (int i = 0; i < AXES; i++)
					last_meas[i] = m.z[i];
				track_step(res);
			end
			OP_REUSE: begin
				if (trk_on)
					track_step(res);
			end
			default: ;  // unused code: state untouched, boxes zero
		endcase
		res.on = trk_on;
		return res;
	endfunction

	// ---------------------------------------------------------------
	// Driver: measurement transactions from the pending queue
	// ---------------------------------------------------------------
	int gap_left;

	always @(posedge clk or negedge arst_n) begin
		meas_item_t m;
		if (!arst_n) begin
			item_in.valid  <= 1'b0;
			item_in.op     <= OP_INIT;
			item_in.meas_x <= '0;
			item_in.meas_y <= '0;
			item_in.meas_w <= '0;
			item_in.meas_h <= '0;
			gap_left = 0;
		end else begin
			if (item_in.valid && item_in.ready) begin
				m.op   = item_in.op;
				m.z[0] = item_in.meas_x;
				m.z[1] = item_in.meas_y;
				m.z[2] = item_in.meas_w;
				m.z[3] = item_in.meas_h;
				expected_boxes = {expected_boxes, predict_box(m)};
				n_in++;
			end
			if (!item_in.valid || item_in.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					item_in.valid <= 1'b0;
				end else if (!quiet && $urandom_range(0, 7) == 0) begin
					gap_left = $urandom_range(1, 11) - 1;
					item_in.valid <= 1'b0;
				end else if (pending_meas.size() > 0) begin
					m = pending_meas.pop_front();
					item_in.valid  <= 1'b1;
					item_in.op     <= m.op;
					item_in.meas_x <= m.z[0];
					item_in.meas_y <= m.z[1];
					item_in.meas_w <= m.z[2];
					item_in.meas_h <= m.z[3];
				end else begin
					item_in.valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Monitor: result transactions, random stalls and one long hold-off
	// ---------------------------------------------------------------
	int  stall_left;
	int  hold_left;
	bit  hold_done;

	task automatic check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		box_result_t exp_r;
		if (!arst_n) begin
			item_out.ready <= 1'b0;
			stall_left = 0;
			hold_left  = 0;
			hold_done  = 0;
		end else begin
			if (item_out.valid && item_out.ready) begin
				n_out++;
				if (expected_boxes.size() == 0) begin
					$error("result transaction with no measurement outstanding");
					errors++;
				end else begin
					exp_r = expected_boxes.pop_front();
					check_field("tracking_on", exp_r.on, item_out.tracking_on);
					check_field("pred_x", exp_r.pred[0], item_out.pred_x);
					check_field("pred_y", exp_r.pred[1], item_out.pred_y);
					check_field("pred_w", exp_r.pred[2], item_out.pred_w);
					check_field("pred_h", exp_r.pred[3], item_out.pred_h);
					check_field("est_x", exp_r.est[0], item_out.est_x);
					check_field("est_y", exp_r.est[1], item_out.est_y);
					check_field("est_w", exp_r.est[2], item_out.est_w);
					check_field("est_h", exp_r.est[3], item_out.est_h);
				end
			end
			if (hold_req && !hold_done) begin
				hold_done = 1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				item_out.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				item_out.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 11) - 1;
				item_out.ready <= 1'b0;
			end else begin
				item_out.ready <= 1'b1;
			end
		end
	end

	// noise registers as the block sees them
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_noise = PROCESS_NOISE_RST;
			r_noise = MEASUREMENT_NOISE_RST;
		end else if (cfg.valid && cfg.ready) begin
			n_cfg++;
			case (cfg.index)
				REG_PROCESS_NOISE:     q_noise = cfg.data;
				REG_MEASUREMENT_NOISE: r_noise = cfg.data;
				default: ;
			endcase
		end
	end

	// watchdog: any accepted transaction resets the count
	always @(posedge clk) begin
		if (!arst_n || (item_in.valid && item_in.ready) || (item_out.valid && item_out.ready)
		    || (cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	task automatic queue_meas(op_t op, int x, int y, int w, int h);
		meas_item_t m;
		m.op   = op;
		m.z[0] = coord_t'(x);
		m.z[1] = coord_t'(y);
		m.z[2] = coord_t'(w);
		m.z[3] = coord_t'(h);
		pending_meas = {pending_meas, m};
	endtask

	task automatic write_noise(reg_idx_t idx, noise_t val);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_meas.size() > 0 || item_in.valid || expected_boxes.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// mostly smooth tracks with jitter; some re-inits, reuses, unused codes and wild boxes
	task automatic queue_tracks(int count);
		int px [AXES];
		int pv [AXES];
		int sel, v;
		meas_item_t m;
		for (int i = 0; i < AXES; i++) begin
			px[i] = $urandom_range(0, 2000) - 1000;
			pv[i] = $urandom_range(0, 40) - 20;
		end
		for (int n = 0; n < count; n++) begin
			sel = $urandom_range(0, 99);
			if (sel < 4)
				m.op = OP_INIT;
			else if (sel < 14)
				m.op = OP_REUSE;
			else if (sel < 17)
				m.op = OP_RESERVED;
			else
				m.op = OP_UPDATE;
			for (int i = 0; i < AXES; i++) begin
				if ($urandom_range(0, 15) == 0) begin
					v = $signed(16'($urandom));
					if ($urandom_range(0, 3) == 0)
						v = $urandom_range(0, 1) ? 32767 : -32768;
				end else begin
					px[i] += pv[i] + $urandom_range(0, 8) - 4;
					if (px[i] > 32767 || px[i] < -32768) begin
						pv[i] = -pv[i];
						px[i] = (px[i] > 0) ? 32767 : -32768;
					end
					v = px[i];
				end
				m.z[i] = coord_t'(v);
			end
			pending_meas = {pending_meas, m};
		end
	endtask

	initial begin
		int setting_q [5];
		int setting_r [5];
		errors = 0; n_in = 0; n_out = 0; n_cfg = 0; n_updates = 0;
		quiet = 0; hold_req = 0; idle_cycles = 0;
		trk_on = 1'b0;
		p00 = '0; p01 = '0; p11 = '0;
		for (int i = 0; i < AXES; i++) begin
			last_meas[i] = '0;
			pos[i]       = '0;
			vel[i]       = '0;
		end
		cfg.valid = 1'b0;
		cfg.index = REG_PROCESS_NOISE;
		cfg.data  = '0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: before-init cases, then extremes of every field
		queue_meas(OP_REUSE, 100, 200, 30, 40);     // reuse before init: zeros
		queue_meas(OP_RESERVED, 5, 6, 7, 8);        // unused code
		queue_meas(OP_UPDATE, 10, 20, 30, 40);      // update initializes
		queue_meas(OP_UPDATE, 14, 25, 30, 41);
		queue_meas(OP_REUSE, 0, 0, 0, 0);
		queue_meas(OP_INIT, 32767, 32767, 32767, 32767);
		queue_meas(OP_UPDATE, 32767, 32767, 32767, 32767);
		queue_meas(OP_UPDATE, -32768, -32768, -32768, -32768);
		queue_meas(OP_REUSE, 1, 1, 1, 1);
		queue_meas(OP_INIT, -32768, -32768, -32768, -32768);
		queue_meas(OP_UPDATE, 32767, -32768, 32767, -32768);
		queue_meas(OP_UPDATE, -1, 0, -1, 0);
		queue_meas(OP_RESERVED, -1, -1, -1, -1);
		queue_meas(OP_INIT, 0, -1, 1, -32768);
		queue_meas(OP_REUSE, 0, 0, 0, 0);
		queue_meas(OP_REUSE, 0, 0, 0, 0);
		queue_tracks(PHASE_ITEMS - 16);
		// back up the block behind a receiver that stops taking results
		repeat (3000) @(posedge clk);
		hold_req = 1;
		drain();

		// noise settings: both extremes, a random pair, then the reset values
		setting_q[1] = 0;          setting_r[1] = 1;
		setting_q[2] = 32'hFFFFFFFF; setting_r[2] = 32'hFFFFFFFF;
		setting_q[3] = $urandom;   setting_r[3] = $urandom_range(1, 32'h7FFFFFFF);
		setting_q[4] = PROCESS_NOISE_RST;
		setting_r[4] = MEASUREMENT_NOISE_RST;
		for (int ph = 1; ph < 5; ph++) begin
			write_noise(REG_PROCESS_NOISE, noise_t'(setting_q[ph]));
			write_noise(REG_MEASUREMENT_NOISE, noise_t'(setting_r[ph]));
			if (ph == 4)
				quiet = 1;  // last stretch runs back to back
			queue_meas(OP_INIT, $urandom_range(0, 600), $urandom_range(0, 600), 50, 80);
			queue_tracks(PHASE_ITEMS - 1);
			drain();
		end

		$display("covered %0d measurements (%0d filter updates), %0d results, %0d noise writes",
		         n_in, n_updates, n_out, n_cfg);
		$display("noise settings: reset, q=0/r=1, both max, random, reset again");
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", errors);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
`default_nettype wire
